// File: src/int_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// Concurrent checks on clk_i, switched off by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS
`define I2DA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define I2DA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2DA_ASSERT_IMP(lbl, ante, cons, msg)
`define I2DA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CNT_W      = $clog2(VALUE_W);
  localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } i2da_state_e;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clr;
    logic dabble;
    logic move;
  } i2da_cell_ctl_t;

endpackage

`default_nettype wire

// File: src/i2da_bcd_cell.sv
// ----------------------------------------------------------------------------
// i2da_bcd_cell
// One BCD digit of the double-dabble chain; also shifts digits upwards
// for output.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_bcd_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  i2da_pkg::i2da_cell_ctl_t   ctl_i,
  input  wire                        shift_i,
  input  wire  [i2da_pkg::DIGIT_W-1:0] digit_i,
  output logic                       carry_o,
  output logic [i2da_pkg::DIGIT_W-1:0] digit_o
);
  import i2da_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d, adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    digit_d = digit_q;
    if (ctl_i.clr) begin
      digit_d = '0;
    end else if (ctl_i.dabble) begin
      digit_d = {adj[DIGIT_W-2:0], shift_i};
    end else if (ctl_i.move) begin
      digit_d = digit_i;
    end
  end

  assign carry_o = ctl_i.dabble & adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

// File: src/int_to_decimal_ascii.sv
// Flow: accept, 32 shift steps of the double-dabble chain, a sign slot that sends
// a leading minus sign for a negative value, a zero skip that drops leading zeros,
// then one word per cycle while the sink is ready. A new number is accepted only in
// idle, once the last word of the previous one is loaded for output.
// Reset: asynchronous, active low; returns to idle and drops output valid.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// 32-bit binary to decimal ASCII text, signed or unsigned, streamed out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "int_to_decimal_ascii_macros.svh"

module int_to_decimal_ascii (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire  [i2da_pkg::VALUE_W-1:0]  s_axis_tdata_i,  // [31:0] value
  input  wire                           s_axis_tuser_i,  // [0] signed_mode
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  output logic [i2da_pkg::CHAR_W-1:0]   m_axis_tdata_o,  // [7:0] character
  output logic                          m_axis_tlast_o   // last
);
  import i2da_pkg::*;

  i2da_state_e          state_q, state_d;
  logic [VALUE_W-1:0]   mag_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [REM_W-1:0]     rem_q;
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  i2da_cell_ctl_t       ctl;
  logic                 in_acc, out_free, out_load, rem_dec;
  logic                 in_neg;
  logic [DIGIT_W-1:0]   digit_w [NUM_DIGITS];
  logic                 carry_w [NUM_DIGITS];
  logic [DIGIT_W-1:0]   top_digit;

  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign in_neg    = s_axis_tuser_i & s_axis_tdata_i[VALUE_W-1];
  assign out_free  = ~out_valid_q | m_axis_tready_i;
  assign top_digit = digit_w[NUM_DIGITS-1];

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    i2da_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .shift_i ((k == 0) ? mag_q[VALUE_W-1] : carry_w[(k == 0) ? 0 : k-1]),
      .digit_i ((k == 0) ? '0 : digit_w[(k == 0) ? 0 : k-1]),
      .carry_o (carry_w[k]),
      .digit_o (digit_w[k])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CONV;
      ST_CONV: if (cnt_q == CNT_W'(VALUE_W - 1)) state_d = ST_SIGN;
      ST_SIGN: if (!neg_q || out_free) state_d = ST_SKIP;
      ST_SKIP: if (top_digit != '0 || rem_q == REM_W'(1)) state_d = ST_EMIT;
      ST_EMIT: if (out_free && rem_q == REM_W'(1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ctl        = '0;
    out_load   = 1'b0;
    out_char_d = CHAR_ZERO + CHAR_W'(top_digit);
    out_last_d = (rem_q == REM_W'(1));
    rem_dec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ctl.clr         = in_acc;
      end
      ST_CONV: ctl.dabble = 1'b1;
      ST_SIGN: begin
        out_load   = neg_q & out_free;
        out_char_d = CHAR_MINUS;
        out_last_d = 1'b0;
      end
      ST_SKIP: begin
        if (top_digit == '0 && rem_q != REM_W'(1)) begin
          ctl.move = 1'b1;
          rem_dec  = 1'b1;
        end
      end
      ST_EMIT: begin
        out_load = out_free;
        ctl.move = out_free;
        rem_dec  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q <= '0;
        rem_q <= REM_W'(NUM_DIGITS);
      end else begin
        if (ctl.dabble) cnt_q <= cnt_q + 1'b1;
        if (rem_dec)    rem_q <= rem_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q <= in_neg;
      mag_q <= in_neg ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;
    end else if (ctl.dabble) begin
      mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
    end
    if (out_load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

  `I2DA_ASSERT_IMP(a_char_range, m_axis_tvalid_o,
    (m_axis_tdata_o >= CHAR_ZERO && m_axis_tdata_o <= CHAR_NINE) ||
    m_axis_tdata_o == CHAR_MINUS, "character outside digit and minus codes")
  `I2DA_ASSERT_IMP(a_minus_not_last, m_axis_tvalid_o && m_axis_tdata_o == CHAR_MINUS,
    !m_axis_tlast_o, "minus sign flagged as last word")
  `I2DA_ASSERT_NXT(a_accept_conv, in_acc, state_q == ST_CONV,
    "accepted word did not start conversion")
  `I2DA_ASSERT_IMP(a_no_overflow, state_q == ST_CONV, !carry_w[NUM_DIGITS-1],
    "carry out of top digit cell")

endmodule

`default_nettype wire
